@@ rtl/core/cmns_pkg.sv @@
// Shared package of the common-mode noise subtractor: field layout of the
// stream beats, register codes, reset values and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmns_pkg;

	localparam int NUM_CHANNELS_DEF = 64;

	// Field widths.
	localparam int CH_W    = 6;
	localparam int ADC_W   = 12;
	localparam int PED_W   = 16;
	localparam int TEMP_W  = 12;
	localparam int IVAL_W  = 16;
	localparam int DIFF_W  = 18;
	localparam int NOISE_W = 17;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = 7;

	// Slave tdata layout, lowest bit first.
	localparam int S_CH_LSB   = 0;
	localparam int S_ADC_LSB  = S_CH_LSB + CH_W;
	localparam int S_PED_LSB  = S_ADC_LSB + ADC_W;
	localparam int S_TRIG_BIT = S_PED_LSB + PED_W;
	localparam int S_TEMP_LSB = S_TRIG_BIT + 1;
	localparam int S_IVAL_LSB = S_TEMP_LSB + TEMP_W;
	localparam int S_USED_W   = S_IVAL_LSB + IVAL_W;
	localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

	// Master tdata layout, lowest bit first.
	localparam int M_CH_LSB    = 0;
	localparam int M_CORR_LSB  = M_CH_LSB + CH_W;
	localparam int M_NOISE_LSB = M_CORR_LSB + DIFF_W;
	localparam int M_NV_BIT    = M_NOISE_LSB + NOISE_W;
	localparam int M_USED_W    = M_NV_BIT + 1;
	localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_LIMIT = 2'd2;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = -12'sd800;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd1600;
	localparam logic [IVAL_W-1:0]        IVAL_LIM_RST  = 16'd20;

	// Beat kinds carried in s_tuser.
	localparam logic KIND_PEDESTAL = 1'b0;
	localparam logic KIND_SAMPLE   = 1'b1;

	typedef struct packed {
		logic cap;      // sample beat accepted: capture fields, read pedestal
		logic ped_we;   // pedestal beat accepted: write the table
		logic smp_wr;   // store the difference, update the accumulators
		logic launch;   // start the division, evaluate the window, clear sums
		logic issue;    // read the next stored difference for output
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;     // captured sample closes the event
		logic div_done; // quotient is ready
		logic pass;     // event passed the temperature and interval checks
		logic rd_free;  // read stage can take a new difference this cycle
		logic rd_busy;  // read stage holds a difference
		logic idx_last; // next read is the highest channel
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/common_mode_noise_subtractor.sv @@
// Top level of the common-mode noise subtractor: stream ports, configuration
// port, controller and datapath. Depends on cmns_pkg, cmns_ctrl and cmns_dp.
`timescale 1ns / 1ps
`default_nettype none

// The block removes the common-mode noise from one event of NUM_CHANNELS
// channel samples. A beat with s_tuser = 0 writes a channel's Q12.4 pedestal
// into the pedestal table. A beat with s_tuser = 1 brings a channel's raw
// sample; its pedestal-corrected difference is stored and, for untriggered
// channels, added to the noise sum. A sample beat first reads the pedestal
// table into a register, then writes the difference store and the
// accumulators. The sample beat with s_tlast closes the event: in a launch
// state the 24-bit noise sum is handed to a restoring divider, which divides
// it by the untriggered channel count, one quotient bit per cycle,
// truncating toward zero; an all-triggered event gives noise 0 with
// noise_valid low. The temperature window and interval limit are checked at
// the same time. A passing event then emits NUM_CHANNELS beats, channel 0
// upward, one per cycle while the output is not stalled, as set by the
// single read port of the difference store, with m_tlast on the highest
// channel; a failing event emits nothing. New beats are accepted again as
// soon as the last store read is done, while the final result may still sit
// in the output register. A channel missing from an event reuses its
// difference from an earlier event. Configuration writes are taken at any
// time but are meant for idle periods.

module common_mode_noise_subtractor #(
	parameter int NUM_CHANNELS = cmns_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration: index 0 temp_low, 1 temp_high, 2 interval_limit.
	input  wire logic                            cfg_we,
	input  wire logic [cmns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cmns_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// s_tdata from bit 0: channel[5:0], adc_sample[17:6], pedestal_value[33:18],
	// trigger_hit[34], temperature[46:35], interval[62:47], zero[63].
	input  wire logic [cmns_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: kind[0].
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	// Output stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata from bit 0: out_channel[5:0], corrected_value[23:6],
	// cm_noise[40:24], noise_valid[41], zero[47:42].
	output logic [cmns_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                 m_tlast
);
	import cmns_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The controller decides when beats are taken and what the datapath does
	// in each cycle; it only sees s_tvalid, the beat kind and the datapath status.
	cmns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds all storage, the divider and the output register.
	cmns_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/core/cmns_div.sv @@
// Restoring divider of the common-mode noise subtractor: signed noise sum by
// unsigned channel count, one quotient bit per cycle, truncating toward zero.
// Depends on cmns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmns_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [cmns_pkg::SUM_W-1:0] dividend,
	input  wire logic [cmns_pkg::CNT_W-1:0]        divisor,
	output logic                                   done,
	output logic [cmns_pkg::DIFF_W-1:0]            quotient
);
	import cmns_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic              neg_q;
	logic [DIFF_W-1:0] quot_q;

	logic [CNT_W:0]   rem_sh;
	logic             ge;
	logic [CNT_W-1:0] rem_nx;
	logic [SUM_W-1:0] mag_nx;
	logic [SUM_W-1:0] quot_full;

	always_comb begin
		rem_sh    = {rem_q, mag_q[SUM_W-1]};
		ge        = rem_sh >= {1'b0, div_q};
		rem_nx    = ge ? CNT_W'(rem_sh - {1'b0, div_q}) : rem_sh[CNT_W-1:0];
		mag_nx    = {mag_q[SUM_W-2:0], ge};
		quot_full = neg_q ? (~mag_nx + 1'b1) : mag_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= mag_nx;
			rem_q <= rem_nx;
			if (step_q == LAST_STEP) begin
				quot_q <= quot_full[DIFF_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

@@ rtl/core/cmns_dp.sv @@
// Datapath of the common-mode noise subtractor: configuration registers,
// pedestal table, difference store, noise accumulators, divider and output.
// Depends on cmns_pkg and cmns_div.
`timescale 1ns / 1ps
`default_nettype none

module cmns_dp #(
	parameter int NUM_CHANNELS = cmns_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [cmns_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cmns_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [cmns_pkg::S_TDATA_W-1:0]       s_tdata,
	input  wire logic                                 s_tlast,
	input  wire cmns_pkg::ctrl_cmd_t                  cmd,
	output cmns_pkg::dp_stat_t                        stat,
	input  wire logic                                 m_tready,
	output logic                                      m_tvalid,
	output logic [cmns_pkg::M_TDATA_W-1:0]            m_tdata,
	output logic                                      m_tlast
);
	import cmns_pkg::*;

	localparam int IDX_W = $clog2(NUM_CHANNELS);
	localparam logic [CH_W:0]    CH_LIMIT = (CH_W + 1)'(NUM_CHANNELS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

	// Configuration.
	logic signed [TEMP_W-1:0] temp_low_q;
	logic signed [TEMP_W-1:0] temp_high_q;
	logic [IVAL_W-1:0]        ival_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q  <= TEMP_LOW_RST;
			temp_high_q <= TEMP_HIGH_RST;
			ival_lim_q  <= IVAL_LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEMP_LOW:       temp_low_q  <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_HIGH:      temp_high_q <= cfg_data[TEMP_W-1:0];
				CFG_INTERVAL_LIMIT: ival_lim_q  <= cfg_data[IVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Input fields.
	logic [CH_W-1:0]  in_ch;
	logic [IDX_W-1:0] in_idx;
	logic             in_ok;
	logic [PED_W-1:0] in_ped;

	assign in_ch  = s_tdata[S_CH_LSB +: CH_W];
	assign in_idx = in_ch[IDX_W-1:0];
	assign in_ok  = {1'b0, in_ch} < CH_LIMIT;
	assign in_ped = s_tdata[S_PED_LSB +: PED_W];

	logic [IDX_W-1:0]         idx_q;
	logic                     ok_q;
	logic [ADC_W-1:0]         adc_q;
	logic                     trig_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [IVAL_W-1:0]        ival_q;
	logic                     last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.cap) begin
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			idx_q  <= in_idx;
			ok_q   <= in_ok;
			adc_q  <= s_tdata[S_ADC_LSB +: ADC_W];
			trig_q <= s_tdata[S_TRIG_BIT];
			temp_q <= s_tdata[S_TEMP_LSB +: TEMP_W];
			ival_q <= s_tdata[S_IVAL_LSB +: IVAL_W];
		end
	end

	// Pedestal table.
	logic [PED_W-1:0] ped_mem [NUM_CHANNELS];
	logic [PED_W-1:0] ped_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.ped_we && in_ok) begin
			ped_mem[in_idx] <= in_ped;
		end
		if (cmd.cap) begin
			ped_rd_q <= ped_mem[in_idx];
		end
	end

	// Difference and accumulation.
	logic signed [PED_W:0]  diff;
	logic [DIFF_W-1:0]      diff_ext;
	logic [SUM_W-1:0]       sum_add;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]       cnt_q;

	assign diff     = $signed({1'b0, adc_q, 4'b0000}) - $signed({1'b0, ped_rd_q});
	assign diff_ext = {{(DIFF_W - PED_W - 1){diff[PED_W]}}, diff};
	assign sum_add  = {{(SUM_W - PED_W - 1){diff[PED_W]}}, diff};

	logic [DIFF_W-1:0] diff_mem [NUM_CHANNELS];

	always_ff @(posedge clk) begin
		if (cmd.smp_wr && ok_q) begin
			diff_mem[idx_q] <= diff_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.launch) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.smp_wr && ok_q && !trig_q) begin
			sum_q <= sum_q + sum_add;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Event checks and common noise.
	logic              pass_q;
	logic              nv_q;
	logic              div_done;
	logic [DIFF_W-1:0] quot;
	logic [DIFF_W-1:0] cn_q;

	cmns_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.launch),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (cmd.launch) begin
			pass_q <= (ival_q <= ival_lim_q) && (temp_q >= temp_low_q) &&
			          (temp_q <= temp_high_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			nv_q <= cnt_q != '0;
		end
		if (div_done) begin
			cn_q <= nv_q ? quot : '0;
		end
	end

	// Emission: index counter, registered store read, output register.
	logic [IDX_W-1:0]  emit_idx_q;
	logic              idx_last;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_last_s1;
	logic [DIFF_W-1:0] rd_diff_s1;
	logic              load;
	logic              m_tvalid_q;

	assign idx_last = emit_idx_q == IDX_LAST;
	assign load     = rd_v_s1 && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				emit_idx_q <= idx_last ? '0 : emit_idx_q + 1'b1;
				rd_v_s1    <= 1'b1;
			end else if (load) begin
				rd_v_s1 <= 1'b0;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_diff_s1 <= diff_mem[emit_idx_q];
			rd_idx_s1  <= emit_idx_q;
			rd_last_s1 <= idx_last;
		end
	end

	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tlast_q;
	logic [M_TDATA_W-1:0] out_word;

	always_comb begin
		out_word                          = '0;
		out_word[M_CH_LSB +: CH_W]       = CH_W'(rd_idx_s1);
		out_word[M_CORR_LSB +: DIFF_W]   = rd_diff_s1 - cn_q;
		out_word[M_NOISE_LSB +: NOISE_W] = cn_q[NOISE_W-1:0];
		out_word[M_NV_BIT]               = nv_q;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= out_word;
			m_tlast_q <= rd_last_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		stat.last     = last_q;
		stat.div_done = div_done;
		stat.pass     = pass_q;
		stat.rd_free  = !rd_v_s1 || load;
		stat.rd_busy  = rd_v_s1;
		stat.idx_last = idx_last;
	end

endmodule

`default_nettype wire

@@ rtl/core/cmns_ctrl.sv @@
// Controller of the common-mode noise subtractor: one-hot state machine that
// sequences sample handling, the noise division and result emission.
// Depends on cmns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmns_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                kind,
	output logic                     s_tready,
	input  wire cmns_pkg::dp_stat_t  stat,
	output cmns_pkg::ctrl_cmd_t      cmd
);
	import cmns_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SAMPLE = 5'b00010,
		ST_LAUNCH = 5'b00100,
		ST_DIVIDE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   ready;
	logic   acc;

	assign ready    = (state_q == ST_IDLE) && !stat.rd_busy;
	assign acc      = s_tvalid && ready;
	assign s_tready = ready;

	always_comb begin
		cmd.cap    = acc && (kind == KIND_SAMPLE);
		cmd.ped_we = acc && (kind == KIND_PEDESTAL);
		cmd.smp_wr = state_q == ST_SAMPLE;
		cmd.launch = state_q == ST_LAUNCH;
		cmd.issue  = (state_q == ST_EMIT) && stat.rd_free;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd.cap) state_nx = ST_SAMPLE;
			ST_SAMPLE: state_nx = stat.last ? ST_LAUNCH : ST_IDLE;
			ST_LAUNCH: state_nx = ST_DIVIDE;
			ST_DIVIDE: begin
				if (stat.div_done) state_nx = stat.pass ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT:   if (cmd.issue && stat.idx_last) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_pass_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && stat.div_done && stat.pass) |=> state_q == ST_EMIT)
		else $error("passing event did not start emission");

	a_launch_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.launch |=> (state_q == ST_DIVIDE && !stat.div_done))
		else $error("divider finished too early");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && stat.idx_last) |=> (state_q == ST_IDLE && !cmd.issue))
		else $error("emission ran past the last channel");

	a_sample_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.smp_wr |-> $past(cmd.cap))
		else $error("sample stored without an accepted beat");

endmodule

`default_nettype wire

@@ sim/common_mode_noise_subtractor_tb.sv @@
// Self-checking testbench of common_mode_noise_subtractor: drives pedestal and sample beats,
// predicts every corrected channel beat and compares it field by field.
// Depends on cmns_pkg and the common_mode_noise_subtractor RTL.
`timescale 1ns / 1ps

module common_mode_noise_subtractor_tb;

	import cmns_pkg::*;

	localparam int CHANNELS      = NUM_CHANNELS_DEF;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS  = 40;

	typedef struct {
		logic                     kind;
		logic [CH_W-1:0]          channel;
		logic [ADC_W-1:0]         adc;
		logic [PED_W-1:0]         pedestal;
		logic                     trig;
		logic signed [TEMP_W-1:0] temperature;
		logic [IVAL_W-1:0]        interval;
		logic                     last;
	} event_beat_t;

	typedef struct {
		logic [CH_W-1:0]    channel;
		logic [DIFF_W-1:0]  corrected;
		logic [NOISE_W-1:0] noise;
		logic               noise_valid;
		logic               last;
	} corrected_beat_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;

	// Predictor state: pedestals, stored differences, event accumulators and limits.
	logic [PED_W-1:0]         pedestal_copy [CHANNELS];
	logic [DIFF_W-1:0]        difference_copy [CHANNELS];
	logic [SUM_W-1:0]         noise_sum_acc   = '0;
	logic [CNT_W-1:0]         noise_count_acc = '0;
	logic signed [TEMP_W-1:0] window_low      = TEMP_LOW_RST;
	logic signed [TEMP_W-1:0] window_high     = TEMP_HIGH_RST;
	logic [IVAL_W-1:0]        interval_max    = IVAL_LIM_RST;

	corrected_beat_t pending_corrections[$];

	bit tx_gaps_on     = 1'b1;
	bit rx_gaps_on     = 1'b1;
	int rx_hold_left   = 0;
	int sent_items     = 0;
	int mismatch_count = 0;

	common_mode_noise_subtractor #(
		.NUM_CHANNELS(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL common_mode_noise_subtractor");
		$finish;
	end

	function automatic int rand_temp();
		return int'($urandom_range(0, 2400)) - 800;
	endfunction

	function automatic int rand_ival();
		return int'($urandom_range(0, 65535));
	endfunction

	// Updates the predictor with one accepted beat and queues the corrected
	// channel beats that a closing sample of a passing event produces.
	task automatic predict_corrections(input event_beat_t b);
		int                       d;
		int                       cn;
		int                       corr;
		int                       k;
		logic                     nv;
		logic                     pass;
		logic signed [SUM_W-1:0]  sum_s;
		logic signed [DIFF_W-1:0] ds;
		corrected_beat_t          r;
		if (b.kind == KIND_PEDESTAL) begin
			pedestal_copy[b.channel] = b.pedestal;
			return;
		end
		d = int'({b.adc, 4'b0000}) - int'(pedestal_copy[b.channel]);
		difference_copy[b.channel] = d[DIFF_W-1:0];
		if (!b.trig) begin
			noise_sum_acc   = noise_sum_acc + d[SUM_W-1:0];
			noise_count_acc = noise_count_acc + 1'b1;
		end
		if (!b.last)
			return;
		pass = (b.interval <= interval_max) && (b.temperature >= window_low) &&
			(b.temperature <= window_high);
		cn = 0;
		nv = 1'b0;
		if (noise_count_acc != 0) begin
			sum_s = noise_sum_acc;
			// Integer division of ints truncates toward zero.
			cn = int'(sum_s) / int'(noise_count_acc);
			nv = 1'b1;
		end
		noise_sum_acc   = '0;
		noise_count_acc = '0;
		if (!pass)
			return;
		for (k = 0; k < CHANNELS; k++) begin
			ds            = difference_copy[k];
			corr          = int'(ds) - cn;
			r.channel     = k[CH_W-1:0];
			r.corrected   = corr[DIFF_W-1:0];
			r.noise       = cn[NOISE_W-1:0];
			r.noise_valid = nv;
			r.last        = (k == CHANNELS - 1);
			pending_corrections.push_back(r);
		end
	endtask

	// Offers one beat, sometimes after a few idle cycles, and returns at the
	// clock edge that accepts it. tvalid stays high so that the next call can
	// present new data in the same step without a dip.
	task automatic send_beat(input event_beat_t b);
		logic [S_TDATA_W-1:0] word;
		word                            = '0;
		word[S_CH_LSB +: CH_W]          = b.channel;
		word[S_ADC_LSB +: ADC_W]        = b.adc;
		word[S_PED_LSB +: PED_W]        = b.pedestal;
		word[S_TRIG_BIT]                = b.trig;
		word[S_TEMP_LSB +: TEMP_W]      = b.temperature;
		word[S_IVAL_LSB +: IVAL_W]      = b.interval;
		if (tx_gaps_on && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= b.kind;
		s_tlast  <= b.last;
		do @(posedge clk); while (!s_tready);
		predict_corrections(b);
		sent_items++;
	endtask

	task automatic send_sample(input int ch, input int adc, input bit trig, input bit last,
		input int temp, input int ival);
		event_beat_t b;
		b.kind        = KIND_SAMPLE;
		b.channel     = ch[CH_W-1:0];
		b.adc         = adc[ADC_W-1:0];
		b.pedestal    = $urandom_range(0, 65535);
		b.trig        = trig;
		b.temperature = temp[TEMP_W-1:0];
		b.interval    = ival[IVAL_W-1:0];
		b.last        = last;
		send_beat(b);
	endtask

	// The fields other than channel and value are noise that the block ignores.
	task automatic send_pedestal(input int ch, input int value, input bit last);
		event_beat_t b;
		b.kind        = KIND_PEDESTAL;
		b.channel     = ch[CH_W-1:0];
		b.adc         = $urandom_range(0, 4095);
		b.pedestal    = value[PED_W-1:0];
		b.trig        = $urandom_range(0, 1);
		b.temperature = rand_temp();
		b.interval    = $urandom_range(0, 65535);
		b.last        = last;
		send_beat(b);
	endtask

	// Complete event over every channel in ascending order, closed inside the limits.
	task automatic send_full_event();
		int ch;
		for (ch = 0; ch < CHANNELS; ch++)
			send_sample(ch, $urandom_range(0, 4095), $urandom_range(0, 99) < 30,
				ch == CHANNELS - 1, rand_temp(),
				(ch == CHANNELS - 1) ? int'($urandom_range(0, interval_max)) : rand_ival());
	endtask

	// Stops offering beats, waits for every expected result and lets a
	// failing event finish its division before anything else happens.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_corrections.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(input int low, input int high, input int limit);
		logic [TEMP_W-1:0] lo_bits;
		logic [TEMP_W-1:0] hi_bits;
		drain_results();
		lo_bits   = low[TEMP_W-1:0];
		hi_bits   = high[TEMP_W-1:0];
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TEMP_LOW;
		cfg_data  <= {{(CFG_DATA_W - TEMP_W){lo_bits[TEMP_W-1]}}, lo_bits};
		@(posedge clk);
		cfg_index <= CFG_TEMP_HIGH;
		cfg_data  <= {{(CFG_DATA_W - TEMP_W){hi_bits[TEMP_W-1]}}, hi_bits};
		@(posedge clk);
		cfg_index <= CFG_INTERVAL_LIMIT;
		cfg_data  <= limit[IVAL_W-1:0];
		@(posedge clk);
		cfg_we       <= 1'b0;
		window_low   = lo_bits;
		window_high  = hi_bits;
		interval_max = limit[IVAL_W-1:0];
	endtask

	// One event drawn at random: mostly ascending well-formed events, some
	// shuffled ones with repeats, and some bursts of pedestal updates.
	task automatic send_random_event();
		int mode;
		int n;
		int ch;
		int next_ch;
		int trig_pct;
		int i;
		bit closing;
		mode = $urandom_range(0, 99);
		case ($urandom_range(0, 2))
			0: trig_pct = 0;
			1: trig_pct = 30;
			default: trig_pct = 100;
		endcase
		if (mode < 70) begin
			n  = ($urandom_range(0, 99) < 3) ? CHANNELS : $urandom_range(1, 10);
			ch = (n == CHANNELS) ? 0 : $urandom_range(0, CHANNELS - 1);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 10)
					send_pedestal($urandom_range(0, CHANNELS - 1), $urandom_range(0, 65535),
						$urandom_range(0, 1));
				next_ch = ch + ((n == CHANNELS) ? 1 : $urandom_range(1, 6));
				closing = (i == n - 1) || (next_ch > CHANNELS - 1);
				send_sample(ch, $urandom_range(0, 4095), $urandom_range(0, 99) < trig_pct,
					closing, rand_temp(),
					($urandom_range(0, 99) < 80) ? int'($urandom_range(0, interval_max))
						: rand_ival());
				if (closing)
					break;
				ch = next_ch;
			end
		end else if (mode < 85) begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++)
				send_sample($urandom_range(0, CHANNELS - 1), $urandom_range(0, 4095),
					$urandom_range(0, 99) < trig_pct, i == n - 1, rand_temp(),
					($urandom_range(0, 99) < 80) ? int'($urandom_range(0, interval_max))
						: rand_ival());
		end else begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				send_pedestal($urandom_range(0, CHANNELS - 1), $urandom_range(0, 65535),
					$urandom_range(0, 1));
		end
	endtask

	// Every pedestal entry is written before any sample reads it.
	task automatic test_load_pedestals();
		int ch;
		for (ch = 0; ch < CHANNELS; ch++)
			send_pedestal(ch, (ch == 0) ? 0 : (ch == CHANNELS - 1) ? 65535
				: int'($urandom_range(0, 65535)), $urandom_range(0, 1));
	endtask

	// The first event covers every channel so the difference store is filled
	// before any shorter event reuses old entries.
	task automatic test_full_event();
		send_full_event();
		drain_results();
	endtask

	task automatic test_field_extremes();
		// Largest positive and negative differences; their mean of -7.5 must
		// truncate toward zero. Temperature sits on the lower window edge.
		send_pedestal(0, 0, 1'b0);
		send_pedestal(1, 65535, 1'b0);
		send_sample(0, 4095, 1'b0, 1'b0, rand_temp(), rand_ival());
		send_sample(1, 0, 1'b0, 1'b1, -800, 20);
		// Every channel triggered: noise is zero and flagged invalid.
		send_sample(2, 123, 1'b1, 1'b0, rand_temp(), rand_ival());
		send_sample(5, 4095, 1'b1, 1'b0, rand_temp(), rand_ival());
		send_sample(63, 0, 1'b1, 1'b1, 1600, 0);
		// Interval one above the limit drops the event; the next one must
		// start from cleared accumulators.
		send_sample(10, 2000, 1'b0, 1'b1, 0, 21);
		send_sample(11, 17, 1'b0, 1'b1, 0, 20);
		// A repeated channel counts twice, and a pedestal beat marked last
		// does not close the event.
		send_sample(3, 1000, 1'b0, 1'b0, rand_temp(), rand_ival());
		send_pedestal(40, $urandom_range(0, 65535), 1'b1);
		send_sample(3, 3000, 1'b0, 1'b0, rand_temp(), rand_ival());
		send_sample(4, 2500, 1'b1, 1'b1, 800, 5);
		drain_results();
	endtask

	task automatic test_window_limits();
		// Empty window: nothing passes.
		set_limits(1600, -800, 65535);
		send_sample(20, 1000, 1'b0, 1'b1, 400, 0);
		send_sample(21, 5, 1'b0, 1'b1, -800, 0);
		// Narrow window with a zero interval limit, probed on both sides of each edge.
		set_limits(0, 100, 0);
		send_sample(22, 100, 1'b0, 1'b1, -1, 0);
		send_sample(23, 200, 1'b0, 1'b1, 0, 0);
		send_sample(24, 300, 1'b1, 1'b1, 100, 1);
		send_sample(25, 400, 1'b0, 1'b1, 100, 0);
		send_sample(26, 500, 1'b0, 1'b1, 101, 0);
		// Widest settings accept the largest interval.
		set_limits(-800, 1600, 65535);
		send_sample(27, 4095, 1'b0, 1'b1, 1600, 65535);
		set_limits(TEMP_LOW_RST, TEMP_HIGH_RST, IVAL_LIM_RST);
	endtask

	// One channel sampled over and over: 129 untriggered copies of the most
	// negative difference wrap the count to one and the sum past its 24-bit range.
	task automatic test_accumulator_wrap();
		int i;
		send_pedestal(7, 65535, 1'b0);
		for (i = 0; i < 129; i++)
			send_sample(7, 0, 1'b0, i == 128, rand_temp(),
				(i == 128) ? int'($urandom_range(0, interval_max)) : rand_ival());
		drain_results();
	endtask

	// The receiver holds off long enough for the block to stall its input
	// while a second event is still being offered.
	task automatic test_backpressure();
		int i;
		rx_hold_left = 600;
		send_sample(0, $urandom_range(0, 4095), 1'b0, 1'b1, rand_temp(),
			int'($urandom_range(0, interval_max)));
		for (i = 1; i < 16; i++)
			send_sample(i * 4, $urandom_range(0, 4095), $urandom_range(0, 1), i == 15,
				rand_temp(), (i == 15) ? int'($urandom_range(0, interval_max)) : rand_ival());
		drain_results();
	endtask

	task automatic test_back_to_back();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		repeat (5) send_random_event();
		drain_results();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	task automatic test_random_events();
		int half_mark;
		int lo;
		half_mark = sent_items + RANDOM_ITEMS / 2;
		while (sent_items < half_mark)
			send_random_event();
		lo = $urandom_range(0, 1200) - 800;
		set_limits(lo, $urandom_range(lo + 800, 2400) - 800, $urandom_range(0, 4000));
		half_mark = sent_items + RANDOM_ITEMS / 2;
		while (sent_items < half_mark)
			send_random_event();
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0d ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Output side: checks each accepted beat against the oldest expectation
	// and draws tready for the next cycle.
	initial begin : result_checker
		corrected_beat_t want;
		corrected_beat_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.channel     = m_tdata[M_CH_LSB +: CH_W];
				got.corrected   = m_tdata[M_CORR_LSB +: DIFF_W];
				got.noise       = m_tdata[M_NOISE_LSB +: NOISE_W];
				got.noise_valid = m_tdata[M_NV_BIT];
				got.last        = m_tlast;
				if (pending_corrections.size() == 0) begin
					mismatch_count++;
					$display("%0d ns: unexpected beat, expected none, actual channel %0d",
						$time, got.channel);
				end else begin
					want = pending_corrections.pop_front();
					report_field("out_channel", want.channel, got.channel);
					report_field("corrected_value", want.corrected, got.corrected);
					report_field("cm_noise", want.noise, got.noise);
					report_field("noise_valid", want.noise_valid, got.noise_valid);
					report_field("last_result", want.last, got.last);
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (rx_gaps_on) begin
				m_tready <= ($urandom_range(0, 99) >= 25);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_pedestals();
		test_full_event();
		test_field_extremes();
		test_window_limits();
		test_accumulator_wrap();
		test_backpressure();
		test_back_to_back();
		test_random_events();
		drain_results();
		if (mismatch_count == 0)
			$display("PASS common_mode_noise_subtractor");
		else
			$display("FAIL common_mode_noise_subtractor");
		$finish;
	end

endmodule
